// ===== design/rgb2yuyv_pkg.sv =====
package rgb2yuyv_pkg;

  localparam int CHAN5_MASK = 'h1F;
  localparam int CHAN6_MASK = 'h3F;
  localparam int CHAN5_MAX  = 31;
  localparam int CHAN6_MAX  = 63;
  localparam int BYTE_MAX   = 255;

  // bt.601 studio-range coefficients
  localparam int Y_R = 66;
  localparam int Y_G = 129;
  localparam int Y_B = 25;
  localparam int U_R = -38;
  localparam int U_G = -74;
  localparam int U_B = 112;
  localparam int V_R = 112;
  localparam int V_G = -94;
  localparam int V_B = -18;

  localparam int ROUND_HALF  = 128;
  localparam int LUMA_OFFSET = 16;
  localparam int CHROMA_BIAS = 128 * 256;

  localparam int SUM_W    = 16;  // luma sum stays below 2^16
  localparam int CSUM_W   = 17;  // signed chroma sum
  localparam int CBIAS_W  = 18;

  typedef logic [7:0] byte_t;

  // c*255/31 = 8c + floor(7c/31), the fraction found by compares
  function automatic byte_t widen5(input logic [4:0] c);
    logic [7:0] c7;
    logic [2:0] frac;
    c7   = {c, 3'b000} - {3'b000, c};
    frac = '0;
    for (int k = 1; k <= 7; k++) begin
      if (c7 >= 8'(k * CHAN5_MAX)) frac = frac + 3'd1;
    end
    return {c, 3'b000} + {5'b00000, frac};
  endfunction

  // c*255/63 = 4c + floor(3c/63)
  function automatic byte_t widen6(input logic [5:0] c);
    logic [7:0] c3;
    logic [1:0] frac;
    c3   = {1'b0, c, 1'b0} + {2'b00, c};
    frac = '0;
    for (int k = 1; k <= 3; k++) begin
      if (c3 >= 8'(k * CHAN6_MAX)) frac = frac + 2'd1;
    end
    return {c, 2'b00} + {6'b000000, frac};
  endfunction

  typedef struct packed {
    byte_t r;
    byte_t g;
    byte_t b;
  } rgb_t;

  function automatic rgb_t expand565(input logic [15:0] px);
    rgb_t c;
    c.r = widen5(px[15:11]);
    c.g = widen6(px[10:5]);
    c.b = widen5(px[4:0]);
    return c;
  endfunction

  function automatic logic [SUM_W-1:0] luma_sum(input rgb_t c);
    return SUM_W'(Y_R * c.r + Y_G * c.g + Y_B * c.b + ROUND_HALF);
  endfunction

  function automatic byte_t luma_byte(input logic [SUM_W-1:0] s);
    logic [8:0] y;
    y = {1'b0, s[SUM_W-1:8]} + 9'(LUMA_OFFSET);
    return y[8] ? byte_t'(BYTE_MAX) : y[7:0];
  endfunction

  // floor shift plus 128 done by biasing the sum so it never goes negative
  function automatic byte_t chroma_byte(input logic signed [CSUM_W-1:0] s);
    logic signed [CBIAS_W-1:0] biased;
    biased = CBIAS_W'(s) + CBIAS_W'(CHROMA_BIAS);
    if (biased < 0) begin
      return '0;
    end else if (biased[CBIAS_W-2:16] != '0) begin
      return byte_t'(BYTE_MAX);
    end else begin
      return biased[15:8];
    end
  endfunction

endpackage

// ===== design/rgb565_pair_to_yuyv.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | pixel_first, pixel_second
// out     | output    | out_valid / out_ready | luma_first, chroma_blue, luma_second, chroma_red
//
// four register stages: expand, luma sums and pair average, luma bytes and
// chroma sums, chroma bytes; one pair accepted per cycle unless an output stall has filled the stages.
// each stage holds while the one after it is full and stalled, and empty
// stages fill in, so an output stall backs up into in_ready without loss.
// rst (synchronous) clears the stage valid bits; no other state.
module rgb565_pair_to_yuyv (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] pixel_first,
  input  logic [15:0] pixel_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  luma_first,
  output logic [7:0]  chroma_blue,
  output logic [7:0]  luma_second,
  output logic [7:0]  chroma_red
);
  import rgb2yuyv_pkg::*;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1
  rgb_t px0, px1;
  // stage 2
  logic [SUM_W-1:0] ysum0, ysum1;
  rgb_t avg;
  // stage 3
  byte_t y0_s3, y1_s3;
  logic signed [CSUM_W-1:0] usum, vsum;
  // stage 4
  byte_t y0_s4, y1_s4, u_s4, v_s4;

  rgb_t avg_next;

  assign rdy4 = !v4 || out_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  // truncated average of each expanded channel
  always_comb begin
    logic [8:0] sr, sg, sb;
    sr = {1'b0, px0.r} + {1'b0, px1.r};
    sg = {1'b0, px0.g} + {1'b0, px1.g};
    sb = {1'b0, px0.b} + {1'b0, px1.b};
    avg_next.r = sr[8:1];
    avg_next.g = sg[8:1];
    avg_next.b = sb[8:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      px0 <= expand565(pixel_first);
      px1 <= expand565(pixel_second);
    end
    if (rdy2 && v1) begin
      ysum0 <= luma_sum(px0);
      ysum1 <= luma_sum(px1);
      avg   <= avg_next;
    end
    if (rdy3 && v2) begin
      y0_s3 <= luma_byte(ysum0);
      y1_s3 <= luma_byte(ysum1);
      usum  <= CSUM_W'(U_R * avg.r + U_G * avg.g + U_B * avg.b + ROUND_HALF);
      vsum  <= CSUM_W'(V_R * avg.r + V_G * avg.g + V_B * avg.b + ROUND_HALF);
    end
    if (rdy4 && v3) begin
      y0_s4 <= y0_s3;
      y1_s4 <= y1_s3;
      u_s4  <= chroma_byte(usum);
      v_s4  <= chroma_byte(vsum);
    end
  end

  assign out_valid   = v4;
  assign luma_first  = y0_s4;
  assign chroma_blue = u_s4;
  assign luma_second = y1_s4;
  assign chroma_red  = v_s4;

endmodule

// ===== bench/tb_rgb565_pair_to_yuyv.sv =====
module tb_rgb565_pair_to_yuyv;
  timeunit 1ns;
  timeprecision 1ps;

  import rgb2yuyv_pkg::*;

  localparam int HOLD_CYCLES = 40;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    byte_t y0;
    byte_t u;
    byte_t y1;
    byte_t v;
  } yuyv_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] pixel_first = '0;
  logic [15:0] pixel_second = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  luma_first;
  logic [7:0]  chroma_blue;
  logic [7:0]  luma_second;
  logic [7:0]  chroma_red;

  yuyv_t pending_groups[$];
  yuyv_t oldest_group;
  int    error_count = 0;
  int    pairs_sent = 0;
  int    groups_checked = 0;
  int    quiet_cycles = 0;

  // sender side idling, only touched by the stimulus process
  bit    tx_gaps_on = 1'b1;
  // receiver side controls
  logic  rx_stalls_on = 1'b1;
  int    hold_requests = 0;
  int    holds_served = 0;
  int    rx_hold_left = 0;
  int    rx_burst_left = 0;

  rgb565_pair_to_yuyv u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_first  (pixel_first),
    .pixel_second (pixel_second),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .luma_first   (luma_first),
    .chroma_blue  (chroma_blue),
    .luma_second  (luma_second),
    .chroma_red   (chroma_red)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int widen_chan(input int code, input int code_max);
    return (code * 255) / code_max;
  endfunction

  function automatic byte_t clamp_byte(input int val);
    if (val < 0) return 8'd0;
    if (val > 255) return 8'd255;
    return byte_t'(val);
  endfunction

  function automatic byte_t luma_of_rgb(input int r, input int g, input int b);
    int sum;
    sum = 66 * r + 129 * g + 25 * b + 128;
    return clamp_byte((sum >>> 8) + 16);
  endfunction

  // signed sum, floor shift then re-center on 128
  function automatic byte_t chroma_of_sum(input int sum);
    return clamp_byte((sum >>> 8) + 128);
  endfunction

  function automatic yuyv_t predict_yuyv(input logic [15:0] left, input logic [15:0] right);
    int    r0, g0, b0, r1, g1, b1;
    int    ra, ga, ba;
    yuyv_t grp;
    r0 = widen_chan(int'(left[15:11]), 31);
    g0 = widen_chan(int'(left[10:5]), 63);
    b0 = widen_chan(int'(left[4:0]), 31);
    r1 = widen_chan(int'(right[15:11]), 31);
    g1 = widen_chan(int'(right[10:5]), 63);
    b1 = widen_chan(int'(right[4:0]), 31);
    ra = (r0 + r1) / 2;
    ga = (g0 + g1) / 2;
    ba = (b0 + b1) / 2;
    grp.y0 = luma_of_rgb(r0, g0, b0);
    grp.y1 = luma_of_rgb(r1, g1, b1);
    grp.u  = chroma_of_sum(-38 * ra - 74 * ga + 112 * ba + 128);
    grp.v  = chroma_of_sum(112 * ra - 94 * ga - 18 * ba + 128);
    return grp;
  endfunction

  function automatic int extreme_chan(input int code_max);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return code_max;
      default: return $urandom_range(0, code_max);
    endcase
  endfunction

  function automatic logic [15:0] pick_pixel();
    logic [15:0] px;
    if ($urandom_range(0, 2) != 0) begin
      px = 16'($urandom);
    end else begin
      px = {5'(extreme_chan(31)), 6'(extreme_chan(63)), 5'(extreme_chan(31))};
    end
    return px;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // called at a rising edge; returns at the edge where the pair transfers
  task automatic send_pair(input logic [15:0] left, input logic [15:0] right);
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pixel_first  <= left;
    pixel_second <= right;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_groups.push_back(predict_yuyv(left, right));
    pairs_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_groups.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_pair(16'h0000, 16'h0000);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'hF800, 16'hF800);   // pure red
    send_pair(16'h07E0, 16'h07E0);   // pure green, both chroma sums negative
    send_pair(16'h001F, 16'h001F);   // pure blue
    send_pair(16'hF800, 16'h001F);
    send_pair(16'h07E0, 16'h0000);
    send_pair(16'h2800, 16'h0000);   // odd channel sum, average truncates
    send_pair(16'h0020, 16'h0000);
    send_pair(16'h0001, 16'h0000);
    send_pair(16'h07FF, 16'hF800);
    send_pair(16'hF81F, 16'h07E0);
    send_pair(16'hFFE0, 16'h001F);
    send_pair(16'h8410, 16'h7BEF);
    send_pair(16'hAAAA, 16'h5555);
    send_pair(16'h5555, 16'hAAAA);
  endtask

  task automatic test_random_mixed(input int count);
    for (int i = 0; i < count; i++) begin
      send_pair(16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_random_extremes(input int count);
    for (int i = 0; i < count; i++) begin
      send_pair(pick_pixel(), pick_pixel());
    end
  endtask

  // receiver stops for a long stretch while pairs keep coming
  task automatic test_output_hold(input int count);
    tx_gaps_on = 1'b0;
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < count; i++) begin
      send_pair(pick_pixel(), pick_pixel());
    end
    while (holds_served != hold_requests) @(posedge clk);
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause(input int count);
    test_random_extremes(count);
    wait_drained();
    test_random_extremes(count);
  endtask

  task automatic test_full_rate(input int count);
    tx_gaps_on = 1'b0;
    rx_stalls_on <= 1'b0;
    test_random_extremes(count);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mixed(300);
    test_output_hold(24);
    test_drain_pause(20);
    test_random_extremes(220);
    test_full_rate(200);
    in_valid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_groups.size() != 0) begin
      report_mismatch("groups left over", 0, pending_groups.size());
    end
    $display("covered %0d pixel pairs and %0d yuyv groups: channel extremes, random pairs,",
             pairs_sent, groups_checked);
    $display("random stalls on both sides, a long output hold, a drained pause, full rate");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver: random stall bursts, plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready     <= 1'b0;
      rx_hold_left  <= 0;
      rx_burst_left <= 0;
    end else if (rx_hold_left != 0) begin
      out_ready    <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
      if (rx_hold_left == 1) holds_served <= holds_served + 1;
    end else if (holds_served != hold_requests) begin
      out_ready    <= 1'b0;
      rx_hold_left <= HOLD_CYCLES - 1;
    end else if (rx_burst_left != 0) begin
      out_ready     <= 1'b0;
      rx_burst_left <= rx_burst_left - 1;
    end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
      out_ready     <= 1'b0;
      rx_burst_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_groups.size() == 0) begin
        report_mismatch("group with nothing pending", {luma_first, chroma_blue}, 0);
      end else begin
        oldest_group = pending_groups.pop_front();
        groups_checked++;
        if (luma_first != oldest_group.y0) report_mismatch("luma_first", luma_first,
                                                           oldest_group.y0);
        if (chroma_blue != oldest_group.u) report_mismatch("chroma_blue", chroma_blue,
                                                           oldest_group.u);
        if (luma_second != oldest_group.y1) report_mismatch("luma_second", luma_second,
                                                            oldest_group.y1);
        if (chroma_red != oldest_group.v) report_mismatch("chroma_red", chroma_red,
                                                          oldest_group.v);
      end
    end
  end

  // no transfer on either channel for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
